// ----- rtl/mqbrb_pkg.sv -----
// Package for the multi-queue byte ring buffer.
// Holds the transfer payload types, action codes, state codes and default sizes.
// Depends on nothing.
package mqbrb_pkg;

    localparam int DEF_NUM_QUEUES  = 4;
    localparam int DEF_QUEUE_DEPTH = 512;

    localparam logic [1:0] ACT_ENQ  = 2'd0;
    localparam logic [1:0] ACT_DEQ  = 2'd1;
    localparam logic [1:0] ACT_STAT = 2'd2;

    typedef struct packed {
        logic [1:0] action;
        logic [3:0] queue_id;
        logic [7:0] enqueue_data;
    } t_in_item;

    typedef struct packed {
        logic       ok;
        logic [7:0] read_byte;
        logic       is_empty;
        logic       is_full;
    } t_out_item;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_DONE = 3'b100
    } t_state;

    typedef struct packed {
        logic load;
        logic exec;
    } t_ctrl_cmd;

endpackage

// ----- rtl/mqbrb_ctrl.sv -----
// Controller state machine of the multi-queue byte ring buffer.
// Sequences request capture, execution and result transfer.
// Depends on mqbrb_pkg.
module mqbrb_ctrl
    import mqbrb_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_ctrl_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_out_ready) begin
                    n_state = i_in_valid ? S_EXEC : S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE) || ((r_state == S_DONE) && i_out_ready);
    assign o_out_valid = (r_state == S_DONE);
    assign o_cmd.load  = i_in_valid && o_in_ready;
    assign o_cmd.exec  = (r_state == S_EXEC);

`ifndef SYNTHESIS
    a_load_then_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> o_cmd.exec)
        else $error("captured request was not executed");
    a_exec_then_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.exec |=> (o_out_valid && !o_in_ready) || (o_out_valid && i_out_ready))
        else $error("execution did not present a result");
    a_no_accept_during_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.exec |-> !o_in_ready)
        else $error("input accepted while a request executes");
`endif

endmodule

// ----- rtl/mqbrb_dp.sv -----
// Datapath of the multi-queue byte ring buffer.
// Holds the request register, queue pointers, the shared byte store and the result.
// Depends on mqbrb_pkg.
module mqbrb_dp
    import mqbrb_pkg::*;
#(
    parameter int NUM_QUEUES  = DEF_NUM_QUEUES,
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
)
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_ctrl_cmd i_cmd,
    input  t_in_item  i_item,
    output t_out_item o_item
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QID_W = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int TOTAL = NUM_QUEUES * QUEUE_DEPTH;
    localparam int AW    = $clog2(TOTAL);

    function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
        if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
            return '0;
        end
        return p + 1'b1;
    endfunction

    t_in_item         r_req;
    logic [PTR_W-1:0] r_front [NUM_QUEUES];
    logic [PTR_W-1:0] r_rear  [NUM_QUEUES];
    logic [7:0]       r_mem   [TOTAL];
    logic [7:0]       r_rd_data;
    logic             r_rd_sel;
    logic             r_ok;
    logic             r_empty;
    logic             r_full;

    logic [QID_W-1:0] qi;
    logic             q_ok;
    logic [PTR_W-1:0] cur_f;
    logic [PTR_W-1:0] cur_r;
    logic [PTR_W-1:0] n_f;
    logic [PTR_W-1:0] n_r;
    logic             do_enq;
    logic             do_deq;
    logic             n_ok;
    logic [AW-1:0]    addr;

    always_comb begin
        qi     = r_req.queue_id[QID_W-1:0];
        q_ok   = ({1'b0, r_req.queue_id} < 5'(NUM_QUEUES));
        cur_f  = r_front[qi];
        cur_r  = r_rear[qi];
        do_enq = q_ok && (r_req.action == ACT_ENQ) && (next_ptr(cur_r) != cur_f);
        do_deq = q_ok && (r_req.action == ACT_DEQ) && (cur_f != cur_r);
        n_f    = do_deq ? next_ptr(cur_f) : cur_f;
        n_r    = do_enq ? next_ptr(cur_r) : cur_r;
        n_ok   = do_enq || do_deq || (q_ok && (r_req.action == ACT_STAT));
        addr   = AW'(qi) * AW'(QUEUE_DEPTH) + AW'(do_enq ? n_r : n_f);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_QUEUES; k++) begin
                r_front[k] <= '0;
                r_rear[k]  <= '0;
            end
        end else if (i_cmd.exec && q_ok) begin
            r_front[qi] <= n_f;
            r_rear[qi]  <= n_r;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && do_enq) begin
            r_mem[addr] <= r_req.enqueue_data;
        end
        if (i_cmd.exec && do_deq) begin
            r_rd_data <= r_mem[addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ok     <= 1'b0;
            r_rd_sel <= 1'b0;
            r_empty  <= 1'b0;
            r_full   <= 1'b0;
        end else if (i_cmd.exec) begin
            r_ok     <= n_ok;
            r_rd_sel <= do_deq;
            r_empty  <= q_ok && (n_f == n_r);
            r_full   <= q_ok && (next_ptr(n_r) == n_f);
        end
    end

    assign o_item.ok        = r_ok;
    assign o_item.read_byte = r_rd_sel ? r_rd_data : 8'd0;
    assign o_item.is_empty  = r_empty;
    assign o_item.is_full   = r_full;

`ifndef SYNTHESIS
    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_empty && r_full))
        else $error("queue reported both empty and full");
    a_read_needs_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_sel |-> r_ok)
        else $error("read byte selected without a successful dequeue");
    a_single_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.exec |-> !(do_enq && do_deq))
        else $error("enqueue and dequeue in one step");
`endif

endmodule

// ----- rtl/multi_queue_byte_ring_buffer_top.sv -----
// Multi-queue byte ring buffer: independent byte FIFOs sharing one byte store.
// A request is captured into the request register when accepted, executed in the execute
// state, and its result is registered and held valid in the done state until it is taken.
// A new request is accepted only when idle or as the result is taken, never while one executes;
// the execute step uses the single byte store port and pointer update.
// Reset clears all queue pointers; store contents are not cleared.
// Depends on mqbrb_pkg, mqbrb_ctrl and mqbrb_dp.
module multi_queue_byte_ring_buffer_top
    import mqbrb_pkg::*;
#(
    parameter int NUM_QUEUES  = DEF_NUM_QUEUES,
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
)
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_item
);

    t_ctrl_cmd cmd;

    mqbrb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd)
    );

    mqbrb_dp #(
        .NUM_QUEUES  (NUM_QUEUES),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_item  (i_item),
        .o_item  (o_item)
    );

endmodule
